// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Text terminal screen store package
// Screen geometry, derived widths, operation codes, character codes and the
// controller state type shared by the screen store modules.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int COLUMNS    = 40;
  localparam int ROWS       = 24;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CHAR_W = 7;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] LOWER_FIRST = 8'h61;
  localparam logic [7:0] LOWER_LAST  = 8'h7A;
  localparam logic [7:0] UPPER_MASK  = 8'h5F;
  localparam logic [7:0] CR_CODE     = 8'h0D;
  localparam logic [7:0] PRINT_FIRST = 8'h20;
  localparam logic [7:0] PRINT_LAST  = 8'h5F;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_FILL  = 4'b1000
  } state_t;

endpackage

// ===== rtl/text_terminal_screen_store_unit.sv =====
// ----------------------------------------------------------------------------
// Text terminal screen store
// A glass teletype screen held in one RAM of ROWS x COLUMNS seven-bit cells,
// with a cursor and scroll-up.
//
// An operation beat is taken when start is high and busy is low. Each
// operation gives exactly one result beat, shown for one cycle while
// out_strobe is high; the receiver cannot hold it off.
// A put that does not scroll, and the unused operation code, give their
// result in the cycle after the beat. A read passes through the registered
// RAM read and then the result register. A put that scrolls copies every
// cell one row up through the RAM, one cell a cycle, then fills the bottom
// row with spaces. A clear writes spaces to every cell, one a cycle. The
// single RAM port pair sets this pace.
// After reset the block runs a clearing pass over every cell with busy high,
// then accepts operations with the cursor at home.
// ----------------------------------------------------------------------------
module text_terminal_screen_store_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_code,
  input  logic [9:0] in_cell_index,
  output logic       out_strobe,
  output logic [6:0] out_cell_char,
  output logic [5:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic       out_scrolled
);

  import tts_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'(CELL_COUNT - COLUMNS);

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic              wv_r, wv_nxt;
  logic              pend_r, pend_nxt;
  logic              scr_r, scr_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              ostb_r, ostb_nxt;
  logic [6:0]        ochar_r, ochar_nxt;
  logic              oscr_r, oscr_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic [7:0]        code;
  logic              is_cr;
  logic              is_print;
  logic [COL_W:0]    col_inc;
  logic              wrap;
  logic              row_adv;
  logic              at_last_row;
  logic [ADDR_W-1:0] cur_addr;
  logic              accept;

  tts_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    code = in_char_code;
    if (in_char_code >= LOWER_FIRST && in_char_code <= LOWER_LAST) begin
      code = in_char_code & UPPER_MASK;
    end
    is_cr       = (code == CR_CODE);
    is_print    = (code >= PRINT_FIRST) && (code <= PRINT_LAST);
    col_inc     = {1'b0, col_r} + 1'b1;
    wrap        = (col_inc == (COL_W + 1)'(COLUMNS));
    row_adv     = is_cr || (is_print && wrap);
    at_last_row = (row_r == ROW_W'(ROWS - 1));
    cur_addr    = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ptr_nxt   = ptr_r;
    wa_nxt    = wa_r;
    wv_nxt    = 1'b0;
    pend_nxt  = pend_r;
    scr_nxt   = scr_r;
    rd_ok_nxt = rd_ok_r;
    ostb_nxt  = 1'b0;
    ochar_nxt = ochar_r;
    oscr_nxt  = oscr_r;
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = code[CHAR_W-1:0];
    ram_raddr = ADDR_W'(in_cell_index);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ochar_nxt = '0;
          oscr_nxt  = 1'b0;
          case (in_operation)
            OP_PUT: begin
              if (is_cr || is_print) begin
                ram_we  = is_print;
                col_nxt = (is_cr || wrap) ? '0 : col_inc[COL_W-1:0];
                if (row_adv && !at_last_row) begin
                  row_nxt = row_r + 1'b1;
                end
              end
              if ((is_cr || is_print) && row_adv && at_last_row) begin
                state_nxt = S_SHIFT;
                ptr_nxt   = '0;
                pend_nxt  = 1'b1;
                scr_nxt   = 1'b1;
              end else begin
                ostb_nxt = 1'b1;
              end
            end
            OP_READ: begin
              rd_ok_nxt = (int'(in_cell_index) < CELL_COUNT);
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              ptr_nxt   = '0;
              pend_nxt  = 1'b1;
              scr_nxt   = 1'b0;
              state_nxt = S_FILL;
            end
            default: begin
              ostb_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        ochar_nxt = rd_ok_r ? ram_rdata : '0;
        ostb_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SHIFT: begin
        ram_raddr = ptr_r + ADDR_W'(COLUMNS);
        ram_we    = wv_r;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata;
        if (ptr_r == BOTTOM_ADDR) begin
          state_nxt = S_FILL;
        end else begin
          wv_nxt  = 1'b1;
          wa_nxt  = ptr_r;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = SPACE_CHAR;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
          ostb_nxt  = pend_r;
          ochar_nxt = '0;
          oscr_nxt  = scr_r;
          pend_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      col_r   <= '0;
      row_r   <= '0;
      ptr_r   <= '0;
      wv_r    <= 1'b0;
      pend_r  <= 1'b0;
      scr_r   <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ptr_r   <= ptr_nxt;
      wv_r    <= wv_nxt;
      pend_r  <= pend_nxt;
      scr_r   <= scr_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wa_r    <= wa_nxt;
    rd_ok_r <= rd_ok_nxt;
    ochar_r <= ochar_nxt;
    oscr_r  <= oscr_nxt;
  end

  assign out_strobe     = ostb_r;
  assign out_cell_char  = ochar_r;
  assign out_cursor_col = 6'(col_r);
  assign out_cursor_row = 5'(row_r);
  assign out_scrolled   = oscr_r;

endmodule

// ===== rtl/tts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== verif/text_terminal_screen_store_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text terminal screen store testbench
// Sends put, read, clear and unused-code operations to the screen store and
// predicts every result beat from a private copy of the screen and cursor.
// A directed opening covers the field extremes and the special codes. A long
// random stream of text and line breaks follows, driving the cursor to the
// bottom row so that scrolling is exercised, with reads of nearby cells.
// ----------------------------------------------------------------------------
module text_terminal_screen_store_unit_tb;
  import tts_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM = 560;
  localparam int LIMIT = (N_RANDOM + 40) * (CELL_COUNT + 8) * 4 + CELL_COUNT * 4;
  localparam logic [9:0] INDEX_TOP = 10'd1023;

  typedef struct packed {
    logic [6:0] cell_char;
    logic [5:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
  } screen_result_t;

  class screen_checker;
    logic [6:0]     screen [CELL_COUNT];
    int             col;
    int             row;
    int             failures;
    screen_result_t pending_results [$];

    function new();
      foreach (screen[i]) screen[i] = SPACE_CHAR;
      col = 0;
      row = 0;
      failures = 0;
    endfunction

    function bit store_char(logic [7:0] code);
      logic [7:0] c;
      c = code;
      if (c >= LOWER_FIRST && c <= LOWER_LAST) c = c & UPPER_MASK;
      if (c == CR_CODE) begin
        col = 0;
        row++;
      end else if (c >= PRINT_FIRST && c <= PRINT_LAST) begin
        screen[row * COLUMNS + col] = c[6:0];
        col++;
      end else begin
        return 1'b0;
      end
      if (col >= COLUMNS) begin
        col = 0;
        row++;
      end
      if (row >= ROWS) begin
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = SPACE_CHAR;
        row = ROWS - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_op(logic [1:0] op, logic [7:0] code, logic [9:0] idx);
      screen_result_t r;
      r = '0;
      case (op)
        OP_PUT: begin
          r.scrolled = store_char(code);
        end
        OP_READ: begin
          if (idx < CELL_COUNT) r.cell_char = screen[idx];
        end
        OP_CLEAR: begin
          foreach (screen[i]) screen[i] = SPACE_CHAR;
          col = 0;
          row = 0;
        end
        default: ;
      endcase
      r.cursor_col = col[5:0];
      r.cursor_row = row[4:0];
      pending_results.push_back(r);
    endfunction

    function void check_beat(screen_result_t got);
      screen_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result beat with no operation outstanding");
        failures++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.cell_char !== exp.cell_char) begin
        $error("cell_char: expected %0h, got %0h", exp.cell_char, got.cell_char);
        failures++;
      end
      if (got.cursor_col !== exp.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", exp.cursor_col, got.cursor_col);
        failures++;
      end
      if (got.cursor_row !== exp.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", exp.cursor_row, got.cursor_row);
        failures++;
      end
      if (got.scrolled !== exp.scrolled) begin
        $error("scrolled: expected %0b, got %0b", exp.scrolled, got.scrolled);
        failures++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_operation = '0;
  logic [7:0] in_char_code = '0;
  logic [9:0] in_cell_index = '0;
  logic       busy;
  logic       out_strobe;
  logic [6:0] out_cell_char;
  logic [5:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic       out_scrolled;

  screen_checker sb = new();
  bit            idle_on = 1'b1;
  int            cycle_count = 0;

  text_terminal_screen_store_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_strobe     (out_strobe),
    .out_cell_char  (out_cell_char),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $error("timeout after %0d cycles", LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      sb.check_beat({out_cell_char, out_cursor_col, out_cursor_row, out_scrolled});
    end
  end

  task automatic send_op(input logic [1:0] op, input logic [7:0] code,
                         input logic [9:0] idx);
    int gap;
    if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_op(op, code, idx);
  endtask

  task automatic send_random();
    int         pick;
    int         line;
    logic [1:0] op;
    logic [7:0] code;
    logic [9:0] idx;
    pick = $urandom_range(0, 199);
    code = 8'($urandom);
    idx  = 10'($urandom);
    if (pick < 150) begin
      op = OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 25) code = CR_CODE;
      else if (pick < 55) code = 8'($urandom_range(PRINT_FIRST, PRINT_LAST));
      else if (pick < 82) code = 8'($urandom_range(LOWER_FIRST, LOWER_LAST));
    end else if (pick < 188) begin
      op = OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        line = (sb.row > 0 && $urandom_range(0, 1)) ? sb.row - 1 : sb.row;
        idx = 10'(line * COLUMNS + $urandom_range(0, COLUMNS - 1));
      end else if (pick < 85) begin
        idx = 10'($urandom_range(0, CELL_COUNT - 1));
      end else begin
        idx = 10'($urandom_range(CELL_COUNT, INDEX_TOP));
      end
    end else if (pick < 199) begin
      op = OP_UNUSED;
    end else begin
      op = OP_CLEAR;
    end
    send_op(op, code, idx);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_op(OP_READ, 8'h00, 10'd0);
    send_op(OP_READ, 8'hFF, 10'(CELL_COUNT - 1));
    send_op(OP_READ, 8'h00, 10'(CELL_COUNT));
    send_op(OP_READ, 8'hFF, INDEX_TOP);
    send_op(OP_UNUSED, 8'hFF, INDEX_TOP);
    send_op(OP_PUT, LOWER_FIRST, 10'd0);
    send_op(OP_PUT, LOWER_LAST, INDEX_TOP);
    send_op(OP_PUT, 8'h60, 10'd0);
    send_op(OP_PUT, 8'h7B, 10'd0);
    send_op(OP_PUT, 8'h00, 10'd0);
    send_op(OP_PUT, 8'hFF, 10'd0);
    send_op(OP_PUT, 8'h1F, 10'd0);
    send_op(OP_PUT, 8'h7F, 10'd0);
    send_op(OP_PUT, 8'hE1, 10'd0);
    send_op(OP_PUT, PRINT_FIRST, 10'd0);
    send_op(OP_PUT, PRINT_LAST, 10'd0);
    send_op(OP_PUT, 8'h41, 10'd0);
    send_op(OP_PUT, CR_CODE, 10'd0);
    send_op(OP_READ, 8'h00, 10'd0);
    send_op(OP_READ, 8'h00, 10'd1);
    send_op(OP_READ, 8'h00, 10'd3);
    send_op(OP_CLEAR, 8'hFF, INDEX_TOP);
    send_op(OP_READ, 8'h00, 10'd0);
    send_op(OP_READ, 8'h00, 10'd3);

    for (int i = 0; i < N_RANDOM; i++) send_random();

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tts_pkg.sv
rtl/tts_ram.sv
rtl/text_terminal_screen_store_unit.sv
verif/text_terminal_screen_store_unit_tb.sv
